FILE: rtl/artff_pkg.sv
// Shared constants and types for the first-fit address range table.
package artff_pkg;

    localparam int MAX_RANGES = 64;
    localparam int ADDR_W     = 48;
    localparam int PAGE_BYTES = 4096;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HANDLE_W   = 6;
    localparam int TYPE_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [ADDR_W-1:0] PG      = ADDR_W'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PG_MASK = ~(PG - ADDR_W'(1));

    localparam logic [TYPE_W-1:0] REQ_LOCATE  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_INSERT  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_REMOVE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        logic              guard;
        logic [IDX_W-1:0]  nxt;
    } t_entry;

endpackage

FILE: rtl/address_range_table_first_fit_core.sv
// Top level of the first-fit address range table: sequencer, entry memory, slot bookkeeping.
//
// One request at a time. start is taken when busy is low; exactly one result
// follows, shown for a single cycle with o_done high, and the receiver cannot
// stall it. The ranges live in one entry memory (base, length, guard, order
// link) with a synchronous read; requests walk the address-ordered
// chain one entry per cycle, the next read address taken from the link field
// of the word just read. A locate walks the chain; an insert walks it, then
// checks overlap and writes, then updates the link; a reserve walks the gaps,
// checks the end, walks again to place, then writes; a remove walks the chain
// and then unlinks. A full table or a bad handle is answered without a walk.
// A new request may be given in the same cycle that the previous result is
// shown. No clearing pass is needed after reset: slot valid bits reset to zero.
module address_range_table_first_fit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [artff_pkg::TYPE_W-1:0]      i_req_type,
    input  logic [artff_pkg::ADDR_W-1:0]      i_request_addr,
    input  logic [artff_pkg::ADDR_W-1:0]      i_request_size,
    input  logic [artff_pkg::ADDR_W-1:0]      i_limit_low,
    input  logic [artff_pkg::ADDR_W-1:0]      i_limit_high,
    input  logic                              i_request_guard,
    input  logic [artff_pkg::HANDLE_W-1:0]    i_entry_handle,
    output logic                              o_done,
    output logic [artff_pkg::STATUS_W-1:0]    o_status,
    output logic [artff_pkg::ADDR_W-1:0]      o_result_addr,
    output logic [artff_pkg::ADDR_W-1:0]      o_result_size,
    output logic                              o_result_guard,
    output logic [artff_pkg::HANDLE_W-1:0]    o_result_handle
);
    import artff_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_GAPEND = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_LINK   = 3'd4;
    localparam logic [2:0] S_REM    = 3'd5;

    // what the walk is doing
    localparam logic [1:0] M_LOC   = 2'd0;
    localparam logic [1:0] M_GAP   = 2'd1;
    localparam logic [1:0] M_PLACE = 2'd2;
    localparam logic [1:0] M_REM   = 2'd3;

    t_entry r_mem [MAX_RANGES];
    t_entry r_rd;                       // registered read data
    logic [IDX_W-1:0] r_slot;           // slot that r_rd came from

    logic [MAX_RANGES-1:0] r_valid;
    logic [IDX_W-1:0]      r_first;
    logic [CNT_W-1:0]      r_count;

    logic [2:0]            r_state;
    logic [1:0]            r_mode;
    logic [CNT_W-1:0]      r_k;
    logic                  r_is_res;

    // latched request
    logic [ADDR_W-1:0]     r_va, r_sz, r_hi, r_prev;
    logic                  r_g;
    logic [HANDLE_W-1:0]   r_h;

    // order neighbors
    logic                  r_have_prev, r_have_succ, r_found;
    logic [IDX_W-1:0]      r_prev_slot, r_succ_slot, r_new, r_nextval;
    t_entry                r_prev_w, r_rem_w;
    logic [ADDR_W-1:0]     r_succ_base;

    assign busy = (r_state != S_IDLE);

    // walk bookkeeping
    logic last;
    assign last = ((r_k + CNT_W'(1)) == r_count);

    // locate hit test
    logic [ADDR_W-1:0] loc_a, loc_e;
    logic              loc_hit;
    always_comb begin
        loc_a = r_rd.base;
        loc_e = r_rd.base + r_rd.len;
        if (r_rd.guard) begin
            loc_a = loc_a - PG;
            loc_e = loc_e + PG;
        end
        loc_hit = (loc_a <= r_va) && (r_va < loc_e);
    end

    // gap search on one range, pages rounded out and guards widened
    logic [ADDR_W-1:0] gp_rs, gp_re, gp_rsc;
    logic              gp_skip, gp_fit, gp_brk, gap_found;
    always_comb begin
        gp_rs = r_rd.base & PG_MASK;
        gp_re = (r_rd.base + r_rd.len + PG - ADDR_W'(1)) & PG_MASK;
        if (r_g || r_rd.guard) begin
            gp_rs = gp_rs - PG;
            gp_re = gp_re + PG;
        end
        gp_skip   = gp_re < r_prev;
        gp_rsc    = (gp_rs > r_hi) ? r_hi : gp_rs;
        gp_fit    = (r_prev + r_sz) <= gp_rsc;
        gp_brk    = gp_re >= r_hi;
        gap_found = (r_mode == M_GAP) && !gp_skip && gp_fit;
    end

    logic end_fit;
    assign end_fit = (r_prev + r_sz) <= r_hi;

    // overlap with order neighbors, guards ignored
    logic ov;
    assign ov = (r_have_prev && ((r_va - r_prev_w.base) < r_prev_w.len)) ||
                (r_have_succ && ((r_succ_base - r_va) < r_sz));

    // lowest free slot
    logic [IDX_W-1:0] free_slot;
    always_comb begin
        free_slot = IDX_W'(MAX_RANGES - 1);
        for (int i = MAX_RANGES - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_slot = IDX_W'(i);
        end
    end

    logic h_ok;
    assign h_ok = ({1'b0, i_entry_handle} < (HANDLE_W + 1)'(MAX_RANGES)) &&
                  r_valid[i_entry_handle[IDX_W-1:0]];

    // memory ports
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    t_entry           wr_data;
    assign rd_addr = (r_state == S_WALK && !gap_found) ? r_rd.nxt : r_first;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_prev_slot;
        wr_data = r_prev_w;
        unique case (r_state)
            S_DECIDE: begin
                wr_en   = !ov;
                wr_addr = free_slot;
                wr_data = '{base: r_va, len: r_sz, guard: r_g,
                            nxt: r_have_succ ? r_succ_slot : '0};
            end
            S_LINK: begin
                wr_en       = 1'b1;
                wr_data.nxt = r_new;
            end
            S_REM: begin
                wr_en       = r_found && r_have_prev;
                wr_data.nxt = r_nextval;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd   <= r_mem[rd_addr];
        r_slot <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_first <= '0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_va        <= i_request_addr;
                        r_sz        <= i_request_size;
                        r_hi        <= i_limit_high;
                        r_prev      <= i_limit_low;
                        r_g         <= i_request_guard;
                        r_h         <= i_entry_handle;
                        r_is_res    <= (i_req_type == REQ_RESERVE);
                        r_k         <= '0;
                        r_have_prev <= 1'b0;
                        r_have_succ <= 1'b0;
                        r_found     <= 1'b0;
                        unique case (i_req_type) inside
                            REQ_LOCATE: begin
                                r_mode <= M_LOC;
                                if (r_count == '0) begin
                                    o_done   <= 1'b1;
                                    o_status <= ST_NONE;
                                end else begin
                                    r_state <= S_WALK;
                                end
                            end
                            REQ_RESERVE, REQ_INSERT: begin
                                if (r_count >= CNT_W'(MAX_RANGES)) begin
                                    o_done   <= 1'b1;
                                    o_status <= ST_FULL;
                                end else if (i_req_type == REQ_RESERVE) begin
                                    r_mode  <= M_GAP;
                                    r_state <= (r_count == '0) ? S_GAPEND : S_WALK;
                                end else begin
                                    r_mode  <= M_PLACE;
                                    r_state <= (r_count == '0) ? S_DECIDE : S_WALK;
                                end
                            end
                            default: begin
                                r_mode <= M_REM;
                                if (!h_ok) begin
                                    o_done   <= 1'b1;
                                    o_status <= ST_BAD;
                                end else begin
                                    r_state <= S_WALK;
                                end
                            end
                        endcase
                        o_result_addr   <= '0;
                        o_result_size   <= '0;
                        o_result_guard  <= 1'b0;
                        o_result_handle <= '0;
                    end
                end
                S_WALK: begin
                    r_k <= r_k + CNT_W'(1);
                    unique case (r_mode)
                        M_LOC: begin
                            if (loc_hit) begin
                                r_state         <= S_IDLE;
                                o_done          <= 1'b1;
                                o_status        <= ST_OK;
                                o_result_addr   <= r_rd.base;
                                o_result_size   <= r_rd.len;
                                o_result_guard  <= r_rd.guard;
                                o_result_handle <= HANDLE_W'(r_slot);
                            end else if (last) begin
                                r_state  <= S_IDLE;
                                o_done   <= 1'b1;
                                o_status <= ST_NONE;
                            end
                        end
                        M_GAP: begin
                            if (gap_found) begin
                                // read of the first entry is issued this cycle
                                r_va   <= r_prev;
                                r_mode <= M_PLACE;
                                r_k    <= '0;
                            end else if (gp_skip) begin
                                if (last) r_state <= S_GAPEND;
                            end else begin
                                r_prev <= gp_re;
                                if (gp_brk || last) r_state <= S_GAPEND;
                            end
                        end
                        M_PLACE: begin
                            if (r_rd.base <= r_va) begin
                                r_have_prev <= 1'b1;
                                r_prev_slot <= r_slot;
                                r_prev_w    <= r_rd;
                                if (last) r_state <= S_DECIDE;
                            end else begin
                                r_have_succ <= 1'b1;
                                r_succ_slot <= r_slot;
                                r_succ_base <= r_rd.base;
                                r_state     <= S_DECIDE;
                            end
                        end
                        default: begin
                            if (HANDLE_W'(r_slot) == r_h) begin
                                r_found   <= 1'b1;
                                r_rem_w   <= r_rd;
                                r_nextval <= last ? '0 : r_rd.nxt;
                                r_state   <= S_REM;
                            end else begin
                                r_have_prev <= 1'b1;
                                r_prev_slot <= r_slot;
                                r_prev_w    <= r_rd;
                                if (last) r_state <= S_REM;
                            end
                        end
                    endcase
                end
                S_GAPEND: begin
                    if (end_fit) begin
                        r_va   <= r_prev;
                        r_mode <= M_PLACE;
                        r_k    <= '0;
                        r_state <= (r_count == '0) ? S_DECIDE : S_WALK;
                    end else begin
                        r_state  <= S_IDLE;
                        o_done   <= 1'b1;
                        o_status <= ST_NONE;
                    end
                end
                S_DECIDE: begin
                    if (ov) begin
                        r_state  <= S_IDLE;
                        o_done   <= 1'b1;
                        o_status <= r_is_res ? ST_NONE : ST_BAD;
                    end else begin
                        r_valid[free_slot] <= 1'b1;
                        r_count            <= r_count + CNT_W'(1);
                        r_new              <= free_slot;
                        o_result_addr      <= r_va;
                        o_result_size      <= r_sz;
                        o_result_guard     <= r_g;
                        o_result_handle    <= HANDLE_W'(free_slot);
                        if (r_have_prev) begin
                            r_state <= S_LINK;
                        end else begin
                            r_first  <= free_slot;
                            r_state  <= S_IDLE;
                            o_done   <= 1'b1;
                            o_status <= ST_OK;
                        end
                    end
                end
                S_LINK: begin
                    r_state  <= S_IDLE;
                    o_done   <= 1'b1;
                    o_status <= ST_OK;
                end
                S_REM: begin
                    if (r_found && !r_have_prev) r_first <= r_nextval;
                    r_valid[r_h[IDX_W-1:0]] <= 1'b0;
                    if (r_count != '0) r_count <= r_count - CNT_W'(1);
                    r_state         <= S_IDLE;
                    o_done          <= 1'b1;
                    o_status        <= ST_OK;
                    o_result_addr   <= r_rem_w.base;
                    o_result_size   <= r_rem_w.len;
                    o_result_guard  <= r_rem_w.guard;
                    o_result_handle <= r_h;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // the fill count always matches the valid bits
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("range count differs from valid slots");

    // a result only ends a request that was in progress or just taken
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    // table never grows past its size
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count overflow");
`endif

endmodule
